[design/pla_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pla_pkg - shared constants for the path length accumulator
// Field widths, default parameter values, and the reset scale value.
// ----------------------------------------------------------------------------
package pla_pkg;

	// default parameter values
	localparam int COORD_BITS_DEF = 17;
	localparam int FRAC_BITS_DEF  = 8;

	// radicand bit pairs covered by the square root
	localparam int SQ_PAIRS = 26;
	localparam int RAD_W    = 2 * SQ_PAIRS;

	// result and scale widths
	localparam int TOTAL_W = 48;
	localparam int UM_W    = 49;
	localparam int SCALE_W = 32;
	localparam int HALF_W  = SCALE_W / 2;
	localparam int PROD_W  = TOTAL_W + HALF_W;

	// 25400/96 um per pixel in Q16 (96 DPI)
	localparam logic [SCALE_W-1:0] SCALE_RESET = 32'd17339733;

	// saturation limits
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
	localparam logic [UM_W-1:0]    UM_MAX    = '1;

endpackage
`default_nettype wire

[design/path_length_accumulator_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// path_length_accumulator_top - Euclidean path length accumulator
// Sums the distance between successive pointer positions, in pixels (Q8)
// and in micrometres through a programmable scale.
// ----------------------------------------------------------------------------
// The first position after reset is only stored and produces no output.
// Every later position produces one result and keeps the input side busy
// from its transfer until the sequencer is idle again. In between come the
// squaring of dx and then dy, the bit-serial square root, which retires one
// root bit per cycle over SQ_PAIRS + FRAC_BITS steps, the accumulate, the
// low and high halves of the 48x16 scale multiply and the output state. The
// result sits in an output register, so a new position is taken while a
// finished result still waits; the block only holds in its output state
// when that register is still full. Writes to cfg_wdata take effect on the
// next result and do not change the running total.
module path_length_accumulator_top #(
	parameter int COORD_BITS = pla_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = pla_pkg::FRAC_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// position input
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic signed [COORD_BITS-1:0] pos_x,
	input  wire logic signed [COORD_BITS-1:0] pos_y,
	// result output
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [pla_pkg::TOTAL_W-1:0]      total_px_q8,
	output logic [pla_pkg::UM_W-1:0]         total_um,
	// scale register
	input  wire logic                        cfg_we,
	input  wire logic [pla_pkg::SCALE_W-1:0] cfg_wdata
);
	import pla_pkg::*;

	// root steps, root and remainder widths
	localparam int ROOT_N = SQ_PAIRS + FRAC_BITS;
	localparam int REM_W  = ROOT_N + 2;
	localparam int CNT_W  = $clog2(ROOT_N);
	localparam int SQ_W   = 2 * COORD_BITS;

	// sequencer codes
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SQ_X   = 3'd1;
	localparam logic [2:0] ST_SQ_Y   = 3'd2;
	localparam logic [2:0] ST_ROOT   = 3'd3;
	localparam logic [2:0] ST_ACC    = 3'd4;
	localparam logic [2:0] ST_MUL_LO = 3'd5;
	localparam logic [2:0] ST_MUL_HI = 3'd6;
	localparam logic [2:0] ST_DONE   = 3'd7;

	logic [2:0]            state_q;
	logic                  have_prev_q;
	logic [COORD_BITS-1:0] prev_x_q, prev_y_q;
	logic [COORD_BITS-1:0] dx_q, dy_q;
	logic [RAD_W-1:0]      rad_q;
	logic [REM_W-1:0]      rem_q;
	logic [ROOT_N-1:0]     root_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [TOTAL_W-1:0]    total_q;
	logic [PROD_W-1:0]     prod_q;
	logic [SCALE_W-1:0]    scale_q;
	logic                  out_valid_q;
	logic [TOTAL_W-1:0]    out_px_q;
	logic [UM_W-1:0]       out_um_q;

	// signed differences, one bit wider than a coordinate
	logic signed [COORD_BITS:0] diff_x, diff_y;
	logic [COORD_BITS:0]        abs_x, abs_y;
	// shared squarer
	logic [COORD_BITS-1:0]      sq_in;
	logic [SQ_W-1:0]            sq_out;
	// root step
	logic [REM_W-1:0]           rem_sh, trial;
	logic                       take;
	// accumulate and scale
	logic [TOTAL_W:0]           acc_sum;
	logic [PROD_W-1:0]          prod_hi;
	logic [PROD_W-1:0]          um_full;

	assign in_ready    = (state_q == ST_IDLE);
	assign out_valid   = out_valid_q;
	assign total_px_q8 = out_px_q;
	assign total_um    = out_um_q;

	// absolute coordinate differences
	always_comb begin
		diff_x = {pos_x[COORD_BITS-1], pos_x} - {prev_x_q[COORD_BITS-1], prev_x_q};
		diff_y = {pos_y[COORD_BITS-1], pos_y} - {prev_y_q[COORD_BITS-1], prev_y_q};
		abs_x  = diff_x[COORD_BITS] ? -diff_x : diff_x;
		abs_y  = diff_y[COORD_BITS] ? -diff_y : diff_y;
	end

	// one squarer, used for dx then dy
	assign sq_in  = (state_q == ST_SQ_X) ? dx_q : dy_q;
	assign sq_out = SQ_W'(sq_in) * SQ_W'(sq_in);

	// one restoring square root step per cycle
	always_comb begin
		rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
		trial  = {root_q, 2'b01};
		take   = (rem_sh >= trial);
	end

	// saturating add and scale products
	assign acc_sum = {1'b0, total_q} + (TOTAL_W+1)'(root_q);
	assign prod_hi = PROD_W'(total_q) * PROD_W'(scale_q[SCALE_W-1:HALF_W]);
	assign um_full = prod_q >> FRAC_BITS;

	// scale register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
		end else if (cfg_we) begin
			scale_q <= cfg_wdata;
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			have_prev_q <= 1'b0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// drain on transfer; the output cycle sets valid itself
			if (out_valid_q && out_ready && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						prev_x_q    <= pos_x;
						prev_y_q    <= pos_y;
						have_prev_q <= 1'b1;
						if (have_prev_q) begin
							state_q <= ST_SQ_X;
						end
					end
				end
				ST_SQ_X:   state_q <= ST_SQ_Y;
				ST_SQ_Y:   state_q <= ST_ROOT;
				ST_ROOT: begin
					if (cnt_q == CNT_W'(ROOT_N - 1)) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					total_q <= (acc_sum >= {1'b0, TOTAL_MAX}) ? TOTAL_MAX
					                                          : acc_sum[TOTAL_W-1:0];
					state_q <= ST_MUL_LO;
				end
				ST_MUL_LO: state_q <= ST_MUL_HI;
				ST_MUL_HI: state_q <= ST_DONE;
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				dx_q <= abs_x[COORD_BITS-1:0];
				dy_q <= abs_y[COORD_BITS-1:0];
			end
			ST_SQ_X: begin
				rad_q  <= RAD_W'(sq_out);
				rem_q  <= '0;
				root_q <= '0;
				cnt_q  <= '0;
			end
			ST_SQ_Y: begin
				rad_q <= rad_q + RAD_W'(sq_out);
			end
			ST_ROOT: begin
				rem_q  <= take ? (rem_sh - trial) : rem_sh;
				root_q <= {root_q[ROOT_N-2:0], take};
				rad_q  <= rad_q << 2;
				cnt_q  <= cnt_q + CNT_W'(1);
			end
			ST_MUL_LO: begin
				prod_q <= PROD_W'(total_q) * PROD_W'(scale_q[HALF_W-1:0]);
			end
			ST_MUL_HI: begin
				prod_q <= prod_hi + (prod_q >> HALF_W);
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_px_q <= total_q;
					out_um_q <= (|um_full[PROD_W-1:UM_W]) ? UM_MAX : um_full[UM_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

[tb/path_length_checker.sv]
// ----------------------------------------------------------------------------
// path_length_checker - scoreboard for the path length accumulator
// Watches the position, result and scale ports, keeps its own copy of the
// accumulator state, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module path_length_checker (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	input  wire logic                                  in_ready,
	input  wire logic signed [pla_pkg::COORD_BITS_DEF-1:0] pos_x,
	input  wire logic signed [pla_pkg::COORD_BITS_DEF-1:0] pos_y,
	input  wire logic                                  out_valid,
	input  wire logic                                  out_ready,
	input  wire logic [pla_pkg::TOTAL_W-1:0]           total_px_q8,
	input  wire logic [pla_pkg::UM_W-1:0]              total_um,
	input  wire logic                                  cfg_we,
	input  wire logic [pla_pkg::SCALE_W-1:0]           cfg_wdata,
	output int                                         mismatches,
	output int                                         pending
);
	import pla_pkg::*;

	localparam int CW = COORD_BITS_DEF;
	localparam int FB = FRAC_BITS_DEF;

	typedef struct packed {
		logic [TOTAL_W-1:0] px_q8;
		logic [UM_W-1:0]    um;
	} path_totals_t;

	// predicted totals, oldest first
	path_totals_t totals_q[$];

	// shadow of the block state
	logic signed [CW-1:0] last_x, last_y;
	logic                 seen_pos;
	logic [TOTAL_W-1:0]   run_total;
	logic [SCALE_W-1:0]   scale_q16;

	// one line per mismatch, counted
	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		mismatches++;
	endtask

	// floor(sqrt(sq) * 2^FB), bit-serial restoring root
	function automatic logic [63:0] step_length_q8(input logic [63:0] sq);
		logic [63:0] rad, rem, root, trial;
		rad  = sq << (2 * FB);
		rem  = '0;
		root = '0;
		for (int i = SQ_PAIRS - 1; i >= 0; i--) begin
			rem   = (rem << 2) | ((rad >> (2 * i)) & 64'd3);
			trial = (root << 2) | 64'd1;
			root  = root << 1;
			if (rem >= trial) begin
				rem  = rem - trial;
				root = root | 64'd1;
			end
		end
		return root;
	endfunction

	// micrometres: total * scale / 2^(FB+16), saturating
	function automatic logic [UM_W-1:0] total_to_um(input logic [TOTAL_W-1:0] px,
			input logic [SCALE_W-1:0] scale);
		logic [79:0] prod;
		prod = {32'd0, px} * {48'd0, scale};
		prod = prod >> (FB + 16);
		if (prod > {31'd0, UM_MAX})
			return UM_MAX;
		return prod[UM_W-1:0];
	endfunction

	// advance the shadow state by one position; returns 1 when a result is due
	function automatic bit advance_path(input logic signed [CW-1:0] nx,
			input logic signed [CW-1:0] ny, output path_totals_t res);
		longint      ddx, ddy;
		logic [63:0] len;
		res = '0;
		if (!seen_pos) begin
			last_x   = nx;
			last_y   = ny;
			seen_pos = 1'b1;
			return 1'b0;
		end
		ddx = longint'(nx) - longint'(last_x);
		ddy = longint'(ny) - longint'(last_y);
		if (ddx < 0) ddx = -ddx;
		if (ddy < 0) ddy = -ddy;
		len = step_length_q8(64'(ddx * ddx + ddy * ddy));
		if (len >= {16'd0, TOTAL_MAX - run_total})
			run_total = TOTAL_MAX;
		else
			run_total = run_total + len[TOTAL_W-1:0];
		last_x    = nx;
		last_y    = ny;
		res.px_q8 = run_total;
		res.um    = total_to_um(run_total, scale_q16);
		return 1'b1;
	endfunction

	// channel monitor: results first, then new positions, then scale writes
	always @(posedge clk or negedge arst_n) begin
		path_totals_t want, got;
		if (!arst_n) begin
			last_x     = '0;
			last_y     = '0;
			seen_pos   = 1'b0;
			run_total  = '0;
			scale_q16  = SCALE_RESET;
			totals_q.delete();
			pending    = 0;
			mismatches = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (totals_q.size() == 0) begin
					report_mismatch($sformatf("result with none expected: px_q8=%0d um=%0d",
						total_px_q8, total_um));
				end else begin
					want = totals_q.pop_front();
					if (total_px_q8 !== want.px_q8)
						report_mismatch($sformatf("total_px_q8 got %0d expected %0d",
							total_px_q8, want.px_q8));
					if (total_um !== want.um)
						report_mismatch($sformatf("total_um got %0d expected %0d",
							total_um, want.um));
				end
			end
			if (in_valid && in_ready) begin
				if (advance_path(pos_x, pos_y, got))
					totals_q.push_back(got);
			end
			if (cfg_we)
				scale_q16 = cfg_wdata;
			pending = totals_q.size();
		end
	end

endmodule

[tb/tb_path_length_accumulator_top.sv]
// ----------------------------------------------------------------------------
// tb_path_length_accumulator_top - regression for the path length accumulator
// Drives pointer positions and scale settings with random gaps and stalls;
// the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_path_length_accumulator_top;
	import pla_pkg::*;

	localparam int CW            = COORD_BITS_DEF;
	localparam int HALF_PERIOD   = 4;
	localparam int RESET_CYCLES  = 9;
	localparam int SETTLE_CYCLES = SQ_PAIRS + FRAC_BITS_DEF + 16;
	localparam int CYCLE_LIMIT   = 500000;
	localparam int NUM_PHASES    = 6;
	localparam int PHASE_ITEMS   = 150;
	localparam int PRESSURE_PHASE = 3;
	localparam int NO_IDLE_PHASE  = 2;

	localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};
	localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic signed [CW-1:0]  pos_x, pos_y;
	logic                  out_valid;
	logic                  out_ready;
	logic [TOTAL_W-1:0]    total_px_q8;
	logic [UM_W-1:0]       total_um;
	logic                  cfg_we;
	logic [SCALE_W-1:0]    cfg_wdata;

	int                    mismatches;
	int                    pending;
	int                    cycle_count = 0;
	bit                    no_idle = 1'b0;
	logic signed [CW-1:0]  cur_x = '0, cur_y = '0;
	logic [SCALE_W-1:0]    phase_scale [NUM_PHASES];

	// clock
	always #HALF_PERIOD clk = ~clk;

	path_length_accumulator_top DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.total_px_q8 (total_px_q8),
		.total_um    (total_um),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata)
	);

	path_length_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.total_px_q8 (total_px_q8),
		.total_um    (total_um),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.mismatches  (mismatches),
		.pending     (pending)
	);

	// run-length guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("path_length_accumulator_top regression: fail");
			$finish;
		end
	end

	// result sink with a random stall before each transfer
	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 3);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	// one position transfer, entered and left at a falling edge
	task automatic send_pos(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		pos_x    <= x;
		pos_y    <= y;
		cur_x     = x;
		cur_y     = y;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// pick one coordinate: small pointer move, full range, or an extreme
	function automatic logic signed [CW-1:0] next_coord(input int mode,
			input logic signed [CW-1:0] cur);
		int   step;
		logic [31:0] rnd;
		case (mode)
			0: begin
				step = int'(cur) + int'($urandom_range(0, 16)) - 8;
				return step[CW-1:0];
			end
			1: begin
				rnd = $urandom;
				return rnd[CW-1:0];
			end
			default: begin
				case ($urandom_range(0, 3))
					0: return COORD_MIN;
					1: return COORD_MAX;
					2: return '0;
					default: return '1;
				endcase
			end
		endcase
	endfunction

	task automatic send_random();
		int sel, mode;
		sel  = $urandom_range(0, 9);
		mode = (sel < 5) ? 0 : (sel < 8) ? 1 : 2;
		send_pos(next_coord(mode, cur_x), next_coord(mode, cur_y));
	endtask

	// hold the sender until every expected result is back
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	// drained, then let a trailing first-position update finish
	task automatic wait_idle();
		drain_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_scale(input logic [SCALE_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// stimulus and verdict
	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		pos_x     = '0;
		pos_y     = '0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		phase_scale[0] = '0;
		phase_scale[1] = '1;
		phase_scale[2] = 32'd1;
		phase_scale[3] = 32'd65536;
		phase_scale[4] = $urandom;
		phase_scale[5] = SCALE_RESET;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: first position gives no result, then extremes at reset scale
		send_pos('0, '0);
		send_pos(COORD_MAX, COORD_MAX);
		send_pos(COORD_MIN, COORD_MIN);
		send_pos(COORD_MAX, COORD_MAX);
		send_pos(COORD_MIN, COORD_MAX);
		send_pos(COORD_MAX, COORD_MIN);
		send_pos(COORD_MAX, COORD_MIN);    // no movement
		send_pos('0, '0);
		send_pos(17'sd3, 17'sd4);          // exact root
		send_pos(17'sd4, 17'sd5);          // root of two truncates
		send_pos(-17'sd1, -17'sd1);
		send_pos(17'sd0, 17'sd0);
		send_pos(COORD_MAX, '0);
		send_pos(COORD_MIN, '0);
		send_pos('0, COORD_MIN);
		send_pos('0, COORD_MAX);
		send_pos(17'sd1, 17'sd0);

		// random phases, one scale setting each
		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_idle();
			write_scale(phase_scale[p]);
			no_idle = (p == NO_IDLE_PHASE);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p == PRESSURE_PHASE && i == PHASE_ITEMS / 2)
					drain_results();
				send_random();
			end
		end
		no_idle = 1'b0;

		wait_idle();
		if (mismatches == 0 && pending == 0) begin
			$display("path_length_accumulator_top regression: pass");
		end else begin
			$display("path_length_accumulator_top regression: fail");
		end
		$finish;
	end

endmodule

[path_length_accumulator_top.f]
design/pla_pkg.sv
design/path_length_accumulator_top.sv
tb/path_length_checker.sv
tb/tb_path_length_accumulator_top.sv
